@@ rtl/tcsm_pkg.sv @@
package tcsm_pkg;

	// Height of the panel in rows; row registers saturate at its last row.
	localparam int DISPLAY_ROWS = 240;

	localparam int ROW_W  = 8;
	localparam int VAL_W  = 32;
	localparam int COL_W  = 8;
	localparam int CLR_W  = 16;
	localparam int CFG_W  = 32;

	// Difference of two clamped samples, and its product with a row span.
	localparam int DEN_W  = VAL_W + 1;
	localparam int NUM_W  = DEN_W + ROW_W;
	// The quotient fits in a row; with a proper value range it never exceeds the row span.
	localparam int QBITS  = ROW_W;

	localparam logic [CLR_W-1:0] CLEAR_COLOR = 16'h0000;

	typedef enum logic [1:0] {
		REG_VALUE_MIN  = 2'd0,
		REG_VALUE_MAX  = 2'd1,
		REG_ROW_TOP    = 2'd2,
		REG_ROW_BOTTOM = 2'd3
	} reg_idx_t;

	// Configuration as the datapath sees it, with derived terms.
	typedef struct packed {
		logic signed [VAL_W-1:0] vmin;
		logic signed [VAL_W-1:0] vmax;
		logic [ROW_W-1:0]        top;
		logic [ROW_W-1:0]        bot;
		logic [ROW_W-1:0]        span;
		logic [DEN_W-1:0]        den;
		logic                    ok;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] now;
		logic signed [VAL_W-1:0] prev;
		logic [COL_W-1:0]        col;
		logic [CLR_W-1:0]        color;
	} item_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem_now;
		logic [NUM_W-1:0] rem_prev;
		logic [QBITS-1:0] q_now;
		logic [QBITS-1:0] q_prev;
		logic [COL_W-1:0] col;
		logic [CLR_W-1:0] color;
	} div_t;

endpackage

@@ rtl/tcsm_ifs.sv @@
interface sample_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] sample_now;
	logic signed [31:0] sample_prev;
	logic [7:0]  column;
	logic [15:0] trace_color;

	modport source(output valid, sample_now, sample_prev, column, trace_color, input ready);
	modport sink(input valid, sample_now, sample_prev, column, trace_color, output ready);
endinterface

interface span_if;
	logic        valid;
	logic        ready;
	logic [7:0]  span_column;
	logic [7:0]  span_first_row;
	logic [7:0]  span_last_row;
	logic [15:0] span_color;
	logic        final_span;

	modport source(output valid, span_column, span_first_row, span_last_row, span_color,
		final_span, input ready);
	modport sink(input valid, span_column, span_first_row, span_last_row, span_color,
		final_span, output ready);
endinterface

@@ rtl/tcsm_front.sv @@
module tcsm_front import tcsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output div_t  out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	item_t item_s1;
	logic [DEN_W-1:0] d_now_s2, d_prev_s2;
	logic [COL_W-1:0] col_s2;
	logic [CLR_W-1:0] color_s2;
	div_t div_s3;

	logic signed [VAL_W-1:0] c_now, c_prev;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Clamp high first, then low, so a degenerate range ends at the minimum.
	always_comb begin
		c_now = item_s1.now;
		if (c_now > cfg.vmax) c_now = cfg.vmax;
		if (c_now < cfg.vmin) c_now = cfg.vmin;
		c_prev = item_s1.prev;
		if (c_prev > cfg.vmax) c_prev = cfg.vmax;
		if (c_prev < cfg.vmin) c_prev = cfg.vmin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) item_s1 <= in_data;
		if (rdy2 && v_s1) begin
			d_now_s2  <= {c_now[VAL_W-1], c_now} - {cfg.vmin[VAL_W-1], cfg.vmin};
			d_prev_s2 <= {c_prev[VAL_W-1], c_prev} - {cfg.vmin[VAL_W-1], cfg.vmin};
			col_s2    <= item_s1.col;
			color_s2  <= item_s1.color;
		end
		if (rdy3 && v_s2) begin
			div_s3.rem_now  <= NUM_W'(d_now_s2) * NUM_W'(cfg.span);
			div_s3.rem_prev <= NUM_W'(d_prev_s2) * NUM_W'(cfg.span);
			div_s3.q_now    <= '0;
			div_s3.q_prev   <= '0;
			div_s3.col      <= col_s2;
			div_s3.color    <= color_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = div_s3;

endmodule

@@ rtl/tcsm_divider.sv @@
module tcsm_divider import tcsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic v_s   [QBITS];
	div_t div_s [QBITS];
	logic rdy   [QBITS+1];

	assign rdy[QBITS] = out_ready;

	// One restoring step per stage, quotient bits from the top down.
	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int B = QBITS - 1 - k;
		logic prev_v;
		div_t prev_d, next_d;
		logic [NUM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign prev_v = in_valid;
			assign prev_d = in_data;
		end else begin : g_next
			assign prev_v = v_s[k-1];
			assign prev_d = div_s[k-1];
		end

		assign trial  = NUM_W'(cfg.den) << B;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_comb begin
			next_d = prev_d;
			if (prev_d.rem_now >= trial) begin
				next_d.rem_now   = prev_d.rem_now - trial;
				next_d.q_now[B]  = 1'b1;
			end
			if (prev_d.rem_prev >= trial) begin
				next_d.rem_prev  = prev_d.rem_prev - trial;
				next_d.q_prev[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_v) div_s[k] <= next_d;
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[QBITS-1];
	assign out_data  = div_s[QBITS-1];

endmodule

@@ rtl/tcsm_span_out.sv @@
module tcsm_span_out import tcsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	span_if.source spans
);

	logic             v_q;
	logic             phase_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] lo_q, hi_q;
	logic [CLR_W-1:0] color_q;

	logic [ROW_W-1:0] y_now, y_prev;
	logic             take, beat;

	// The quotient never exceeds the row span, so the row lies in range.
	assign y_now  = cfg.ok ? cfg.bot - in_data.q_now  : cfg.bot;
	assign y_prev = cfg.ok ? cfg.bot - in_data.q_prev : cfg.bot;

	assign beat     = v_q && spans.ready;
	assign in_ready = !v_q || (phase_q && spans.ready);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= 1'b0;
			phase_q <= 1'b0;
		end else if (take) begin
			v_q     <= 1'b1;
			phase_q <= 1'b0;
		end else if (beat) begin
			v_q     <= !phase_q;
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q   <= in_data.col;
			lo_q    <= (y_now < y_prev) ? y_now : y_prev;
			hi_q    <= (y_now < y_prev) ? y_prev : y_now;
			color_q <= in_data.color;
		end
	end

	assign spans.valid          = v_q;
	assign spans.span_column    = col_q;
	assign spans.span_first_row = phase_q ? lo_q : cfg.top;
	assign spans.span_last_row  = phase_q ? hi_q : cfg.bot;
	assign spans.span_color     = phase_q ? color_q : CLEAR_COLOR;
	assign spans.final_span     = phase_q;

endmodule

@@ rtl/trace_column_span_mapper.sv @@
// Maps one segment of a scrolling trace onto two vertical span commands for a
// display. Each sample beat carries the current and previous sample, a column
// and a color; the block answers with two span beats in that column, first a
// black span that clears the plot area from row_top to row_bottom, then a span
// in the trace color from the smaller to the larger mapped row. Samples are
// clamped to value_min..value_max and scaled linearly with truncating
// division onto row_bottom..row_top; a range with value_max not above
// value_min, or rows with row_bottom above row_top, puts the trace on
// row_bottom. A new sample beat can enter every cycle while the pipeline has
// room; the output register takes a segment only when empty or as the last
// segment's drawing span is accepted, since each yields two span beats on
// the single output port. A sample beat passes three front stages, one stage
// per quotient bit of the divider, and the output register. Write the
// configuration only while no segment is in flight.
module trace_column_span_mapper import tcsm_pkg::*; #(
	parameter int PANEL_ROWS = DISPLAY_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	sample_if.sink           samples,
	span_if.source           spans,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Last row a row register may name. A panel taller than the row field
	// can address leaves every field value usable.
	localparam logic [ROW_W-1:0] ROW_LIMIT =
		(PANEL_ROWS - 1 > (1 << ROW_W) - 1) ? {ROW_W{1'b1}} : ROW_W'(PANEL_ROWS - 1);

	logic signed [VAL_W-1:0] vmin_q, vmax_q;
	logic [ROW_W-1:0]        top_q, bot_q;

	cfg_t  cfg;
	item_t item;
	logic  front_v, front_rdy, div_v, div_rdy;
	div_t  front_d, div_d;

	// Register file. Writes take effect at once; no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q <= 32'sd0;
			vmax_q <= 32'sd100;
			top_q  <= 8'd0;
			bot_q  <= 8'd239;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_VALUE_MIN:  vmin_q <= cfg_data;
				REG_VALUE_MAX:  vmax_q <= cfg_data;
				REG_ROW_TOP:    top_q  <= cfg_data[ROW_W-1:0];
				REG_ROW_BOTTOM: bot_q  <= cfg_data[ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Terms that depend only on configuration. Rows past the panel saturate
	// to its last row. The scale applies only when the value range is proper
	// and the bottom row is not above the top row; otherwise every sample
	// lands on the bottom row.
	always_comb begin
		cfg.vmin = vmin_q;
		cfg.vmax = vmax_q;
		cfg.top  = (top_q > ROW_LIMIT) ? ROW_LIMIT : top_q;
		cfg.bot  = (bot_q > ROW_LIMIT) ? ROW_LIMIT : bot_q;
		cfg.span = cfg.bot - cfg.top;
		cfg.den  = {vmax_q[VAL_W-1], vmax_q} - {vmin_q[VAL_W-1], vmin_q};
		cfg.ok   = (vmax_q > vmin_q) && (cfg.bot >= cfg.top);
	end

	assign item.now   = samples.sample_now;
	assign item.prev  = samples.sample_prev;
	assign item.col   = samples.column;
	assign item.color = samples.trace_color;

	// Input register, clamp and offset, then the scale multiply.
	tcsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.in_data   (item),
		.out_valid (front_v),
		.out_ready (front_rdy),
		.out_data  (front_d)
	);

	// Both samples are divided by the value range side by side, one quotient
	// bit per stage.
	tcsm_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (front_v),
		.in_ready  (front_rdy),
		.in_data   (front_d),
		.out_valid (div_v),
		.out_ready (div_rdy),
		.out_data  (div_d)
	);

	// Final row mapping and the register that plays out the two span beats.
	tcsm_span_out u_span_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (div_v),
		.in_ready (div_rdy),
		.in_data  (div_d),
		.spans    (spans)
	);

endmodule

@@ rtl/tcsm_checker.sv @@
module tcsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  span_column,
	input logic [7:0]  span_first_row,
	input logic [7:0]  span_last_row,
	input logic [15:0] span_color,
	input logic        final_span
);

	logic       expect_q;
	logic [7:0] col_q;

	// Tracks whether a clearing span has gone out whose drawing span is due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			expect_q <= !final_span;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && out_ready && !final_span) col_q <= span_column;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_column)
			&& $stable(span_first_row) && $stable(span_last_row)
			&& $stable(span_color) && $stable(final_span))
		else $error("span beat changed while stalled");

	a_pairing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> final_span == expect_q)
		else $error("clearing and drawing spans out of order");

	a_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expect_q |-> span_column == col_q)
		else $error("drawing span column differs from its clearing span");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_span |-> span_first_row <= span_last_row)
		else $error("drawing span rows reversed");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_span |-> span_color == 16'h0000)
		else $error("clearing span not black");

endmodule

bind trace_column_span_mapper tcsm_checker u_tcsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (spans.valid),
	.out_ready      (spans.ready),
	.span_column    (spans.span_column),
	.span_first_row (spans.span_first_row),
	.span_last_row  (spans.span_last_row),
	.span_color     (spans.span_color),
	.final_span     (spans.final_span)
);
